// ===== hdl/cvfg_pkg.sv =====
// Shared constants, stage record types and lookup functions of the chord voice generator.
`default_nettype none

package cvfg_pkg;

   localparam int CHANNELS     = 8;
   localparam int CHAN_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int OUT_CHAN_W   = 3;

   localparam int ROOT_W       = 4;
   localparam int ACC_W        = 2;
   localparam int THIRD_W      = 4;
   localparam int EXT_W        = 15;
   localparam int VCNT_W       = 4;
   localparam int FREQ_W       = 25;

   localparam logic [VCNT_W-1:0] VCOUNT_RESET = 4'd8;
   localparam logic [FREQ_W-1:0] FREQ_MAX     = '1;

   // interval and root-plus-accidental widths
   localparam int IVL_W        = 4;
   localparam int BASE_W       = 6;

   localparam int NOTES        = 12;
   localparam int PC_W         = 4;
   localparam int SEMI_MAX     = 16 + 15 + NOTES * (CHANNELS - 1);
   localparam int SEMI_W       = $clog2(SEMI_MAX + 1);
   localparam int SUM_W        = SEMI_W + 1;
   localparam int OCT_W        = $clog2(SEMI_MAX / NOTES + 1);

   // floor(s / 12) estimate, low by at most one over the semitone range
   localparam int RECIP        = 170;
   localparam int RECIP_SHIFT  = 11;
   localparam int PROD_W       = SEMI_W + 8;

   localparam int TBL_W        = 16;
   localparam int SHIFT_W      = TBL_W + (1 << OCT_W) - 1;

   typedef struct packed {
      logic                     valid;
      logic [CHAN_W-1:0]        chan;
      logic                     sound;
      logic                     last;
      logic [IVL_W-1:0]         ivl;
      logic [CHAN_W-1:0]        oct;
      logic signed [BASE_W-1:0] base;
   } voice_type;

   typedef struct packed {
      logic              valid;
      logic [CHAN_W-1:0] chan;
      logic              sound;
      logic              last;
      logic [SEMI_W-1:0] semi;
      logic [OCT_W-1:0]  quot;
   } semi_type;

   typedef struct packed {
      logic              valid;
      logic [CHAN_W-1:0] chan;
      logic              sound;
      logic              last;
      logic [PC_W-1:0]   pc;
      logic [OCT_W-1:0]  oct;
   } pitch_type;

   // C3..B3 in Hz with 8 fractional bits
   function automatic logic [TBL_W-1:0] base_freq(input logic [PC_W-1:0] pc);
      logic [TBL_W-1:0] f;
      case (pc)
         4'd0:    f = 16'd33487;
         4'd1:    f = 16'd35479;
         4'd2:    f = 16'd37588;
         4'd3:    f = 16'd39823;
         4'd4:    f = 16'd42191;
         4'd5:    f = 16'd44700;
         4'd6:    f = 16'd47360;
         4'd7:    f = 16'd50176;
         4'd8:    f = 16'd53158;
         4'd9:    f = 16'd56320;
         4'd10:   f = 16'd59668;
         4'd11:   f = 16'd63217;
         default: f = '0;
      endcase
      return f;
   endfunction

   // semitone distance of the lowest set extension bit
   function automatic logic [IVL_W-1:0] lowest_set(input logic [EXT_W-1:0] m);
      logic [IVL_W-1:0] k;
      k = '0;
      for (int b = EXT_W - 1; b >= 0; b--) begin
         if (m[b]) k = IVL_W'(b + 1);
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/cvfg_seq.sv =====
// Voice sequencer: walks the interval list of one chord and issues one voice per cycle.
`default_nettype none

module cvfg_seq (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [cvfg_pkg::ROOT_W-1:0]     req_root_note,
   input  wire logic signed [cvfg_pkg::ACC_W-1:0] req_accidental,
   input  wire logic [cvfg_pkg::THIRD_W-1:0]    req_third_interval,
   input  wire logic [cvfg_pkg::EXT_W-1:0]      req_extension_mask,
   input  wire logic [cvfg_pkg::VCNT_W-1:0]     voice_count,
   output cvfg_pkg::voice_type                  voice
);

   typedef enum logic [1:0] {
      PH_ROOT,
      PH_THIRD,
      PH_EXT
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic                                   active_ff, active_in;
   logic [cvfg_pkg::CHAN_W-1:0]            chan_ff, chan_in;
   logic [cvfg_pkg::CHAN_W-1:0]            oct_ff, oct_in;
   logic [cvfg_pkg::THIRD_W-1:0]           third_ff, third_in;
   logic [cvfg_pkg::EXT_W-1:0]             mask_ff, mask_in;
   logic [cvfg_pkg::EXT_W-1:0]             rem_ff, rem_in;
   logic signed [cvfg_pkg::BASE_W-1:0]     base_ff, base_in;
   cvfg_pkg::voice_type                    voice_ff, voice_in;

   logic                                   accept;
   logic                                   last_issue;
   logic [cvfg_pkg::EXT_W-1:0]             rem_next;
   logic [cvfg_pkg::IVL_W-1:0]             ivl_cur;

   always_comb begin
      last_issue = (chan_ff == cvfg_pkg::CHAN_W'(cvfg_pkg::CHANNELS - 1));
      busy       = active_ff && !last_issue;
      accept     = start && !busy;
      rem_next   = rem_ff & (rem_ff - 1'b1);

      unique case (phase_ff)
         PH_ROOT:  ivl_cur = '0;
         PH_THIRD: ivl_cur = cvfg_pkg::IVL_W'(third_ff);
         PH_EXT:   ivl_cur = cvfg_pkg::lowest_set(rem_ff);
         default:  ivl_cur = '0;
      endcase

      phase_in  = phase_ff;
      active_in = active_ff;
      chan_in   = chan_ff;
      oct_in    = oct_ff;
      third_in  = third_ff;
      mask_in   = mask_ff;
      rem_in    = rem_ff;
      base_in   = base_ff;

      if (active_ff) begin
         chan_in = chan_ff + 1'b1;
         if (last_issue) active_in = 1'b0;
         // advance to the next list entry, wrapping an octave higher
         unique case (phase_ff)
            PH_ROOT: begin
               if (third_ff != '0) begin
                  phase_in = PH_THIRD;
               end else if (mask_ff != '0) begin
                  phase_in = PH_EXT;
                  rem_in   = mask_ff;
               end else begin
                  oct_in = oct_ff + 1'b1;
               end
            end
            PH_THIRD: begin
               if (mask_ff != '0) begin
                  phase_in = PH_EXT;
                  rem_in   = mask_ff;
               end else begin
                  phase_in = PH_ROOT;
                  oct_in   = oct_ff + 1'b1;
               end
            end
            PH_EXT: begin
               if (rem_next != '0) begin
                  rem_in = rem_next;
               end else begin
                  phase_in = PH_ROOT;
                  oct_in   = oct_ff + 1'b1;
               end
            end
            default: phase_in = PH_ROOT;
         endcase
      end

      if (accept) begin
         phase_in  = PH_ROOT;
         active_in = 1'b1;
         chan_in   = '0;
         oct_in    = '0;
         third_in  = req_third_interval;
         mask_in   = req_extension_mask;
         base_in   = $signed({{(cvfg_pkg::BASE_W - cvfg_pkg::ROOT_W){1'b0}}, req_root_note})
                     + cvfg_pkg::BASE_W'(req_accidental);
      end

      voice_in.valid = active_ff;
      voice_in.chan  = chan_ff;
      voice_in.sound = (cvfg_pkg::VCNT_W'(chan_ff) < voice_count);
      voice_in.last  = last_issue;
      voice_in.ivl   = ivl_cur;
      voice_in.oct   = oct_ff;
      voice_in.base  = base_ff;
   end

   always_ff @(posedge clock) begin
      oct_ff   <= oct_in;
      third_ff <= third_in;
      mask_ff  <= mask_in;
      rem_ff   <= rem_in;
      base_ff  <= base_in;
      if (reset) begin
         phase_ff       <= PH_ROOT;
         active_ff      <= 1'b0;
         chan_ff        <= '0;
         voice_ff.valid <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         active_ff <= active_in;
         chan_ff   <= chan_in;
         voice_ff  <= voice_in;
      end
   end

   assign voice = voice_ff;

endmodule

`default_nettype wire

// ===== hdl/cvfg_pitch.sv =====
// Pitch stages: semitone sum, octave raise, and split into pitch class and octave.
`default_nettype none

module cvfg_pitch (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cvfg_pkg::voice_type  voice,
   output cvfg_pkg::pitch_type       pitch
);

   cvfg_pkg::semi_type               sum_ff, sum_in;
   cvfg_pkg::semi_type               quot_ff, quot_in;
   cvfg_pkg::pitch_type              pitch_ff, pitch_in;

   logic signed [cvfg_pkg::SUM_W-1:0] sum;
   logic [cvfg_pkg::PROD_W-1:0]       prod;
   logic [cvfg_pkg::SEMI_W-1:0]       rem_raw;

   // stage 1: root + accidental + interval + octaves, raised above zero
   always_comb begin
      sum = cvfg_pkg::SUM_W'(voice.base)
            + $signed(cvfg_pkg::SUM_W'(voice.ivl))
            + $signed(cvfg_pkg::SUM_W'(cvfg_pkg::NOTES * voice.oct));
      sum_in.valid = voice.valid;
      sum_in.chan  = voice.chan;
      sum_in.sound = voice.sound;
      sum_in.last  = voice.last;
      sum_in.quot  = '0;
      if (sum[cvfg_pkg::SUM_W-1]) begin
         sum_in.semi = cvfg_pkg::SEMI_W'(sum + cvfg_pkg::SUM_W'(cvfg_pkg::NOTES));
      end else begin
         sum_in.semi = cvfg_pkg::SEMI_W'(sum);
      end
   end

   // stage 2: quotient estimate by reciprocal multiply
   always_comb begin
      prod         = cvfg_pkg::PROD_W'(sum_ff.semi) * cvfg_pkg::PROD_W'(cvfg_pkg::RECIP);
      quot_in      = sum_ff;
      quot_in.quot = cvfg_pkg::OCT_W'(prod >> cvfg_pkg::RECIP_SHIFT);
   end

   // stage 3: remainder with a single correction step
   always_comb begin
      rem_raw = quot_ff.semi
                - cvfg_pkg::SEMI_W'(cvfg_pkg::NOTES * quot_ff.quot);
      pitch_in.valid = quot_ff.valid;
      pitch_in.chan  = quot_ff.chan;
      pitch_in.sound = quot_ff.sound;
      pitch_in.last  = quot_ff.last;
      if (rem_raw >= cvfg_pkg::SEMI_W'(cvfg_pkg::NOTES)) begin
         pitch_in.pc  = cvfg_pkg::PC_W'(rem_raw - cvfg_pkg::SEMI_W'(cvfg_pkg::NOTES));
         pitch_in.oct = quot_ff.quot + 1'b1;
      end else begin
         pitch_in.pc  = cvfg_pkg::PC_W'(rem_raw);
         pitch_in.oct = quot_ff.quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.valid   <= 1'b0;
         quot_ff.valid  <= 1'b0;
         pitch_ff.valid <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         quot_ff  <= quot_in;
         pitch_ff <= pitch_in;
      end
   end

   assign pitch = pitch_ff;

endmodule

`default_nettype wire

// ===== hdl/cvfg_freq.sv =====
// Frequency stage: base table lookup, octave shift, saturation and result register.
`default_nettype none

module cvfg_freq (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cvfg_pkg::pitch_type            pitch,
   output logic                                rsp_valid,
   output logic [cvfg_pkg::OUT_CHAN_W-1:0]     rsp_channel,
   output logic [cvfg_pkg::FREQ_W-1:0]         rsp_frequency,
   output logic                                rsp_last
);

   logic                                        valid_ff, valid_in;
   logic [cvfg_pkg::OUT_CHAN_W-1:0]             channel_ff, channel_in;
   logic [cvfg_pkg::FREQ_W-1:0]                 freq_ff, freq_in;
   logic                                        last_ff, last_in;

   logic [cvfg_pkg::SHIFT_W-1:0]                wide;
   logic [cvfg_pkg::CHAN_W+cvfg_pkg::OUT_CHAN_W-1:0] chan_ext;

   always_comb begin
      wide     = cvfg_pkg::SHIFT_W'(cvfg_pkg::base_freq(pitch.pc)) << pitch.oct;
      chan_ext = (cvfg_pkg::CHAN_W + cvfg_pkg::OUT_CHAN_W)'(pitch.chan);

      valid_in   = pitch.valid;
      channel_in = chan_ext[cvfg_pkg::OUT_CHAN_W-1:0];
      last_in    = pitch.last;
      if (!pitch.sound) begin
         freq_in = '0;
      end else if (wide > cvfg_pkg::SHIFT_W'(cvfg_pkg::FREQ_MAX)) begin
         freq_in = cvfg_pkg::FREQ_MAX;
      end else begin
         freq_in = cvfg_pkg::FREQ_W'(wide);
      end
   end

   always_ff @(posedge clock) begin
      channel_ff <= channel_in;
      freq_ff    <= freq_in;
      last_ff    <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_channel   = channel_ff;
   assign rsp_frequency = freq_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ===== hdl/chord_voice_frequency_gen_unit.sv =====
// Top level of the chord voice frequency generator.
//
// A chord request is taken on req_* at a clock edge where start is high and
// busy is low. Each request gives exactly one result per voice channel, in
// channel order, on rsp_channel/rsp_frequency/rsp_last, each shown for one
// cycle with rsp_valid high; rsp_last marks the final channel. The receiver
// cannot hold results off, and none is needed: results leave at one a cycle.
// The first result of a request passes the sequencer, sum, quotient,
// remainder and frequency registers in that order. The sequencer issues
// one voice per cycle; busy drops in the cycle the last voice issues, so
// the next request follows without a gap. voice_count is written through
// csr_valid/csr_ready/csr_data; the user must write it only while no
// request is in flight, as the block itself does not enforce this;
// csr_ready is always high. Reset (synchronous) sets voice_count to 8,
// empties the pipeline and leaves busy low.
`default_nettype none

module chord_voice_frequency_gen_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [cvfg_pkg::ROOT_W-1:0]       req_root_note,
   input  wire logic signed [cvfg_pkg::ACC_W-1:0] req_accidental,
   input  wire logic [cvfg_pkg::THIRD_W-1:0]      req_third_interval,
   input  wire logic [cvfg_pkg::EXT_W-1:0]        req_extension_mask,
   output logic                                   rsp_valid,
   output logic [cvfg_pkg::OUT_CHAN_W-1:0]        rsp_channel,
   output logic [cvfg_pkg::FREQ_W-1:0]            rsp_frequency,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [cvfg_pkg::VCNT_W-1:0]       csr_data
);

   logic [cvfg_pkg::VCNT_W-1:0] voice_count_ff, voice_count_in;
   cvfg_pkg::voice_type         voice;
   cvfg_pkg::pitch_type         pitch;

   assign csr_ready      = 1'b1;
   assign voice_count_in = (csr_valid && csr_ready) ? csr_data : voice_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_count_ff <= cvfg_pkg::VCOUNT_RESET;
      end else begin
         voice_count_ff <= voice_count_in;
      end
   end

   cvfg_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_root_note      (req_root_note),
      .req_accidental     (req_accidental),
      .req_third_interval (req_third_interval),
      .req_extension_mask (req_extension_mask),
      .voice_count        (voice_count_ff),
      .voice              (voice)
   );

   cvfg_pitch u_pitch (
      .clock (clock),
      .reset (reset),
      .voice (voice),
      .pitch (pitch)
   );

   cvfg_freq u_freq (
      .clock         (clock),
      .reset         (reset),
      .pitch         (pitch),
      .rsp_valid     (rsp_valid),
      .rsp_channel   (rsp_channel),
      .rsp_frequency (rsp_frequency),
      .rsp_last      (rsp_last)
   );

   // reset empties the whole pipeline and frees the request port
   assert property (@(posedge clock) reset |=> (!rsp_valid && !busy))
      else $error("pipeline not empty after reset");

   // a taken request keeps the port busy until its last voice issues
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || (cvfg_pkg::CHANNELS == 1)))
      else $error("request port free right after a transfer");

   // results of one chord leave in consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a chord's results");

endmodule

`default_nettype wire

// ===== tb/tb_chord_voice_frequency_gen_unit.sv =====
// Self-checking testbench for the chord voice frequency generator unit.
`default_nettype none

module tb_chord_voice_frequency_gen_unit;

   localparam int IDLE_LIMIT  = 500;
   localparam int DRAIN_TAIL  = 20;
   localparam int PHASE_ITEMS = 15;

   typedef struct {
      bit [cvfg_pkg::OUT_CHAN_W-1:0] chan;
      bit [cvfg_pkg::FREQ_W-1:0]     freq;
      bit                            last;
   } voice_result_type;

   // Predicts the per-channel voice frequencies of each chord and checks them in order.
   class chord_voice_ledger;
      voice_result_type                expected_voices[$];
      bit [cvfg_pkg::VCNT_W-1:0]       voice_count;
      int                              mismatches;
      int                              chords_seen;
      int                              voices_checked;

      function new();
         voice_count    = cvfg_pkg::VCOUNT_RESET;
         mismatches     = 0;
         chords_seen    = 0;
         voices_checked = 0;
      endfunction

      function int pending();
         return expected_voices.size();
      endfunction

      // C3..B3 in Hz, 8 fractional bits
      function bit [15:0] octave3_hz(int pc);
         case (pc)
            0:       return 16'd33487;
            1:       return 16'd35479;
            2:       return 16'd37588;
            3:       return 16'd39823;
            4:       return 16'd42191;
            5:       return 16'd44700;
            6:       return 16'd47360;
            7:       return 16'd50176;
            8:       return 16'd53158;
            9:       return 16'd56320;
            10:      return 16'd59668;
            default: return 16'd63217;
         endcase
      endfunction

      function bit [cvfg_pkg::FREQ_W-1:0] voice_hz_fixed(int semis);
         int          pc;
         int          oct;
         bit [63:0]   wide;
         // raise by whole octaves until not negative
         while (semis < 0) semis += cvfg_pkg::NOTES;
         pc  = semis % cvfg_pkg::NOTES;
         oct = semis / cvfg_pkg::NOTES;
         if (oct >= 16) return cvfg_pkg::FREQ_MAX;
         wide = 64'(octave3_hz(pc)) << oct;
         if (wide > 64'(cvfg_pkg::FREQ_MAX)) return cvfg_pkg::FREQ_MAX;
         return wide[cvfg_pkg::FREQ_W-1:0];
      endfunction

      function void note_chord(bit [cvfg_pkg::ROOT_W-1:0] root,
                               bit signed [cvfg_pkg::ACC_W-1:0] acc,
                               bit [cvfg_pkg::THIRD_W-1:0] third,
                               bit [cvfg_pkg::EXT_W-1:0] mask);
         int               ivl[$];
         int               n;
         int               semis;
         voice_result_type v;
         ivl.push_back(0);
         if (third != 0) ivl.push_back(int'(third));
         for (int k = 1; k <= cvfg_pkg::EXT_W; k++) begin
            if (mask[k-1]) ivl.push_back(k);
         end
         n = ivl.size();
         for (int i = 0; i < cvfg_pkg::CHANNELS; i++) begin
            v.chan = cvfg_pkg::OUT_CHAN_W'(i);
            v.freq = '0;
            v.last = (i == cvfg_pkg::CHANNELS - 1);
            if (i < int'(voice_count)) begin
               semis  = int'(root) + int'(acc) + ivl[i % n] + cvfg_pkg::NOTES * (i / n);
               v.freq = voice_hz_fixed(semis);
            end
            expected_voices.push_back(v);
         end
         chords_seen++;
      endfunction

      function void check_voice(logic [cvfg_pkg::OUT_CHAN_W-1:0] chan,
                                logic [cvfg_pkg::FREQ_W-1:0] freq,
                                logic last);
         voice_result_type v;
         if (expected_voices.size() == 0) begin
            $error("unexpected result: channel %0d frequency %0d last %0d", chan, freq, last);
            mismatches++;
            return;
         end
         v = expected_voices.pop_front();
         voices_checked++;
         if (chan !== v.chan) begin
            $error("channel: expected %0d, got %0d", v.chan, chan);
            mismatches++;
         end
         if (freq !== v.freq) begin
            $error("frequency: expected %0d, got %0d (channel %0d)", v.freq, freq, v.chan);
            mismatches++;
         end
         if (last !== v.last) begin
            $error("last: expected %0d, got %0d (channel %0d)", v.last, last, v.chan);
            mismatches++;
         end
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic [cvfg_pkg::ROOT_W-1:0]           req_root_note;
   logic signed [cvfg_pkg::ACC_W-1:0]     req_accidental;
   logic [cvfg_pkg::THIRD_W-1:0]          req_third_interval;
   logic [cvfg_pkg::EXT_W-1:0]            req_extension_mask;
   logic                                  rsp_valid;
   logic [cvfg_pkg::OUT_CHAN_W-1:0]       rsp_channel;
   logic [cvfg_pkg::FREQ_W-1:0]           rsp_frequency;
   logic                                  rsp_last;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [cvfg_pkg::VCNT_W-1:0]           csr_data;

   chord_voice_ledger chords = new();
   int                quiet_cycles;

   chord_voice_frequency_gen_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_root_note      (req_root_note),
      .req_accidental     (req_accidental),
      .req_third_interval (req_third_interval),
      .req_extension_mask (req_extension_mask),
      .rsp_valid          (rsp_valid),
      .rsp_channel        (rsp_channel),
      .rsp_frequency      (rsp_frequency),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         chords.check_voice(rsp_channel, rsp_frequency, rsp_last);
   end

   // abort when nothing has been transferred for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // hold the chord on the request ports until the block takes it
   task automatic send_chord(input logic [cvfg_pkg::ROOT_W-1:0] root,
                             input logic [cvfg_pkg::ACC_W-1:0] acc,
                             input logic [cvfg_pkg::THIRD_W-1:0] third,
                             input logic [cvfg_pkg::EXT_W-1:0] mask);
      start              <= 1'b1;
      req_root_note      <= root;
      req_accidental     <= acc;
      req_third_interval <= third;
      req_extension_mask <= mask;
      do @(posedge clock); while (busy);
      chords.note_chord(root, signed'(acc), third, mask);
   endtask

   // drop start for a rest of the given length, with noise on the request fields
   task automatic rest(input int cycles);
      start <= 1'b0;
      repeat (cycles) begin
         @(posedge clock);
         req_root_note      <= cvfg_pkg::ROOT_W'($urandom);
         req_accidental     <= cvfg_pkg::ACC_W'($urandom);
         req_third_interval <= cvfg_pkg::THIRD_W'($urandom);
         req_extension_mask <= cvfg_pkg::EXT_W'($urandom);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (chords.pending() != 0) @(posedge clock);
   endtask

   task automatic write_voice_count(input logic [cvfg_pkg::VCNT_W-1:0] count);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      chords.voice_count = count;
   endtask

   task automatic random_chord();
      logic [cvfg_pkg::EXT_W-1:0] mask;
      case ($urandom_range(0, 3))
         0:       mask = '0;
         1:       mask = cvfg_pkg::EXT_W'(1) << $urandom_range(0, cvfg_pkg::EXT_W - 1);
         2:       mask = cvfg_pkg::EXT_W'($urandom);
         default: mask = cvfg_pkg::EXT_W'($urandom | $urandom);
      endcase
      send_chord(cvfg_pkg::ROOT_W'($urandom), cvfg_pkg::ACC_W'($urandom),
                 cvfg_pkg::THIRD_W'($urandom_range(0, 15)), mask);
   endtask

   initial begin
      logic [cvfg_pkg::VCNT_W-1:0] phase_counts[6];
      bit                          may_idle;

      reset              = 1'b1;
      start              = 1'b0;
      req_root_note      = '0;
      req_accidental     = '0;
      req_third_interval = '0;
      req_extension_mask = '0;
      csr_valid          = 1'b0;
      csr_data           = '0;
      quiet_cycles       = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed chords at the reset voice count
      send_chord(4'd0, 2'b00, 4'd0, 15'h0000);   // root alone: octaves only
      send_chord(4'd11, 2'b01, 4'd15, 15'h7FFF); // longest interval list
      send_chord(4'd15, 2'b01, 4'd0, 15'h0000);  // highest reachable pitch
      send_chord(4'd0, 2'b11, 4'd0, 15'h0000);   // flat below C: wraps up an octave
      send_chord(4'd0, 2'b10, 4'd3, 15'h4000);   // accidental of -2
      send_chord(4'd1, 2'b10, 4'd7, 15'h5555);
      send_chord(4'd6, 2'b00, 4'd4, 15'h2AAA);
      for (int r = 0; r < 16; r++)
         send_chord(cvfg_pkg::ROOT_W'(r), cvfg_pkg::ACC_W'(r), cvfg_pkg::THIRD_W'(r),
                    cvfg_pkg::EXT_W'(1) << (r % cvfg_pkg::EXT_W));

      // random chords over a spread of voice counts, extremes included
      phase_counts = '{4'd0, 4'd15, 4'd1, 4'd6, 4'd8, 4'd0};
      phase_counts[5] = cvfg_pkg::VCNT_W'($urandom);
      for (int p = 0; p < 6; p++) begin
         write_voice_count(phase_counts[p]);
         may_idle = (p != 4);
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            if (p == 2 && j == 9) drain();
            if (may_idle && $urandom_range(0, 99) < 19) rest($urandom_range(1, 19));
            random_chord();
         end
      end

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("Covered %0d chords and %0d voice results across voice counts 0 to 15,",
               chords.chords_seen, chords.voices_checked);
      $display("with every root, accidental, third and extension bit exercised.");
      if (chords.mismatches == 0 && chords.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
